/* rtl/core/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the clause literal status tracker: command
// codes, literal status codes and the control group of the tally unit.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LITERALS_DEF = 16;
  localparam int VAR_BITS_DEF     = 20;

  // Fixed widths of the port fields
  localparam int CMD_W   = 2;
  localparam int FIELD_W = 20;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [1:0]       status_t;

  // Command codes
  localparam cmd_t CMD_CLEAR    = 2'd0;
  localparam cmd_t CMD_LOAD     = 2'd1;
  localparam cmd_t CMD_ASSIGN   = 2'd2;
  localparam cmd_t CMD_UNASSIGN = 2'd3;

  // Literal status codes
  localparam status_t ST_EMPTY      = 2'd0;
  localparam status_t ST_UNASSIGNED = 2'd1;
  localparam status_t ST_FALSE      = 2'd2;
  localparam status_t ST_TRUE       = 2'd3;

  // Control group from the sequencer to the tally unit
  typedef struct packed {
    logic    clr;
    logic    step;
    status_t status;
  } tally_ctl_t;

  // Result of comparing one stored literal with the command's literal
  typedef struct packed {
    logic    hit_var;
    logic    dup;
    logic    free;
    status_t new_status;
  } match_t;

endpackage

/* rtl/core/clt_store.sv */
// ----------------------------------------------------------------------------
// clt_store
// Literal store: variable and clause polarity of each slot, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module clt_store #(
  parameter int MAX_LITERALS = 16,
  parameter int VAR_BITS     = 20,
  localparam int IDX_W       = $clog2(MAX_LITERALS)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  logic [VAR_BITS-1:0] wvar,
  input  logic                wpol,
  input  logic [IDX_W-1:0]    raddr,
  output logic [VAR_BITS-1:0] rvar,
  output logic                rpol
);

  logic [VAR_BITS:0] mem [MAX_LITERALS];

  // Write one slot, read one slot each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wpol, wvar};
    end
    {rpol, rvar} <= mem[raddr];
  end

endmodule

/* rtl/core/clt_match.sv */
// ----------------------------------------------------------------------------
// clt_match
// Shared compare unit: matches one stored literal against the command's
// literal and forms the slot's new status.
// ----------------------------------------------------------------------------
module clt_match #(
  parameter int VAR_BITS = 20
) (
  input  logic [VAR_BITS-1:0]    entry_var,
  input  logic                   entry_pol,
  input  clt_pkg::status_t       entry_status,
  input  logic [VAR_BITS-1:0]    cmd_var,
  input  logic                   cmd_pol,
  input  logic                   cmd_val,
  input  logic                   cmd_is_assign,
  output clt_pkg::match_t        result
);
  import clt_pkg::*;

  logic occupied;
  logic var_eq;

  assign occupied = (entry_status != ST_EMPTY);
  assign var_eq   = (entry_var == cmd_var);

  // Compare and pick the status an assign or unassign would leave
  always_comb begin
    result.hit_var = occupied && var_eq;
    result.dup     = occupied && var_eq && (entry_pol == cmd_pol);
    result.free    = !occupied;
    if (cmd_is_assign) begin
      result.new_status = (cmd_val == entry_pol) ? ST_TRUE : ST_FALSE;
    end else begin
      result.new_status = ST_UNASSIGNED;
    end
  end

endmodule

/* rtl/core/clt_tally.sv */
// ----------------------------------------------------------------------------
// clt_tally
// Accumulates the clause summary over a slot scan: any true literal, number
// of unassigned literals (saturating at two) and the last unassigned one.
// ----------------------------------------------------------------------------
module clt_tally #(
  parameter int VAR_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  clt_pkg::tally_ctl_t   ctl,
  input  logic [VAR_BITS-1:0]   entry_var,
  input  logic                  entry_pol,
  output logic                  satisfied,
  output logic                  conflict,
  output logic                  unit_valid,
  output logic [VAR_BITS-1:0]   unit_var,
  output logic                  unit_pol
);
  import clt_pkg::*;

  logic                any_true;
  logic [1:0]          n_unas;
  logic [VAR_BITS-1:0] uvar;
  logic                upol;

  // Clear at command start, fold in one slot per step
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      any_true <= 1'b0;
      n_unas   <= 2'd0;
    end else if (ctl.step) begin
      if (ctl.status == ST_TRUE) begin
        any_true <= 1'b1;
      end
      if (ctl.status == ST_UNASSIGNED && n_unas != 2'd2) begin
        n_unas <= n_unas + 2'd1;
      end
    end
  end

  // Capture the unassigned literal's payload
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.status == ST_UNASSIGNED) begin
      uvar <= entry_var;
      upol <= entry_pol;
    end
  end

  assign satisfied  = any_true;
  assign conflict   = !any_true && (n_unas == 2'd0);
  assign unit_valid = !any_true && (n_unas == 2'd1);
  assign unit_var   = uvar;
  assign unit_pol   = upol;

endmodule

/* rtl/core/clause_literal_status_tracker_top.sv */
// ----------------------------------------------------------------------------
// clause_literal_status_tracker_top
// Holds one SAT clause and tracks the status of each literal. A sequencer
// walks the slots through one shared compare unit to apply an assign, unassign
// or load, then walks them again to tally satisfied, conflict and unit.
//
//   channel | handshake      | fields
//   --------+----------------+----------------------------------------------
//   command | start / busy   | command, variable, value_assigned,
//           |                | polarity_in_clause
//   result  | done (strobe)  | satisfied, conflict, unit_valid,
//           |                | unit_variable, unit_polarity, overflow
//
// A beat is taken when start is high and busy is low. Clear scans the slots
// once to tally; assign and unassign scan them to apply the command and again
// to tally; load adds the store write between the two scans. Each scan takes
// one slot a cycle through the single store read port and compare unit, with
// registered read data. busy stays high until done. Reset empties every slot
// at once. The result beat lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module clause_literal_status_tracker_top #(
  parameter int MAX_LITERALS = clt_pkg::MAX_LITERALS_DEF,
  parameter int VAR_BITS     = clt_pkg::VAR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  clt_pkg::cmd_t                command,
  input  logic [clt_pkg::FIELD_W-1:0]  variable,
  input  logic                         value_assigned,
  input  logic                         polarity_in_clause,
  output logic                         done,
  output logic                         satisfied,
  output logic                         conflict,
  output logic                         unit_valid,
  output logic [clt_pkg::FIELD_W-1:0]  unit_variable,
  output logic                         unit_polarity,
  output logic                         overflow
);
  import clt_pkg::*;

  localparam int IDX_W = $clog2(MAX_LITERALS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LITERALS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_LOADFIN,
    S_TALLY,
    S_FINISH
  } state_t;

  state_t              state;
  status_t             entry_status [MAX_LITERALS];

  // Latched command
  cmd_t                cmd;
  logic [VAR_BITS-1:0] cmd_var;
  logic                cmd_val;
  logic                cmd_pol;

  // Scan counter and read pipeline
  logic [IDX_W-1:0]    idx;
  logic                iss_active;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;

  // Load bookkeeping
  logic                dup;
  logic                found_free;
  logic [IDX_W-1:0]    free_idx;

  logic                accept;
  logic                store_we;
  logic [VAR_BITS-1:0] rd_var;
  logic                rd_pol;
  status_t             rd_status;
  match_t              m;
  tally_ctl_t          tctl;
  logic                t_sat;
  logic                t_conf;
  logic                t_unit;
  logic [VAR_BITS-1:0] t_uvar;
  logic                t_upol;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign rd_status = entry_status[rd_idx];
  assign store_we  = (state == S_LOADFIN) && !dup && found_free;

  clt_store #(
    .MAX_LITERALS (MAX_LITERALS),
    .VAR_BITS     (VAR_BITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (free_idx),
    .wvar  (cmd_var),
    .wpol  (cmd_pol),
    .raddr (idx),
    .rvar  (rd_var),
    .rpol  (rd_pol)
  );

  clt_match #(
    .VAR_BITS (VAR_BITS)
  ) u_match (
    .entry_var     (rd_var),
    .entry_pol     (rd_pol),
    .entry_status  (rd_status),
    .cmd_var       (cmd_var),
    .cmd_pol       (cmd_pol),
    .cmd_val       (cmd_val),
    .cmd_is_assign (cmd == CMD_ASSIGN),
    .result        (m)
  );

  // Tally control: clear on accept, step each slot read in the tally scan
  always_comb begin
    tctl.clr    = accept;
    tctl.step   = (state == S_TALLY) && rd_valid;
    tctl.status = rd_status;
  end

  clt_tally #(
    .VAR_BITS (VAR_BITS)
  ) u_tally (
    .clk        (clk),
    .rst        (rst),
    .ctl        (tctl),
    .entry_var  (rd_var),
    .entry_pol  (rd_pol),
    .satisfied  (t_sat),
    .conflict   (t_conf),
    .unit_valid (t_unit),
    .unit_var   (t_uvar),
    .unit_pol   (t_upol)
  );

  // Latch the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= command;
      cmd_var <= VAR_BITS'(variable);
      cmd_val <= value_assigned;
      cmd_pol <= polarity_in_clause;
    end
  end

  // Sequencer, slot status and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iss_active <= 1'b0;
      rd_valid   <= 1'b0;
      done       <= 1'b0;
      overflow   <= 1'b0;
      dup        <= 1'b0;
      found_free <= 1'b0;
      for (int i = 0; i < MAX_LITERALS; i++) begin
        entry_status[i] <= ST_EMPTY;
      end
    end else begin
      done <= 1'b0;

      // Advance the scan counter and the read pipeline
      rd_valid <= iss_active;
      rd_idx   <= idx;
      if (iss_active) begin
        idx <= idx + IDX_W'(1);
        if (idx == LAST_IDX) begin
          iss_active <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            overflow   <= 1'b0;
            dup        <= 1'b0;
            found_free <= 1'b0;
            idx        <= '0;
            iss_active <= 1'b1;
            if (command == CMD_CLEAR) begin
              for (int i = 0; i < MAX_LITERALS; i++) begin
                entry_status[i] <= ST_EMPTY;
              end
              state <= S_TALLY;
            end else begin
              state <= S_APPLY;
            end
          end
        end

        S_APPLY: begin
          if (rd_valid) begin
            if (cmd == CMD_LOAD) begin
              if (m.dup) begin
                dup <= 1'b1;
              end
              if (m.free && !found_free) begin
                found_free <= 1'b1;
                free_idx   <= rd_idx;
              end
            end else if (m.hit_var) begin
              entry_status[rd_idx] <= m.new_status;
            end
            if (rd_idx == LAST_IDX) begin
              if (cmd == CMD_LOAD) begin
                state <= S_LOADFIN;
              end else begin
                idx        <= '0;
                iss_active <= 1'b1;
                state      <= S_TALLY;
              end
            end
          end
        end

        S_LOADFIN: begin
          // Store the new literal or flag a full store
          if (!dup) begin
            if (found_free) begin
              entry_status[free_idx] <= ST_UNASSIGNED;
            end else begin
              overflow <= 1'b1;
            end
          end
          idx        <= '0;
          iss_active <= 1'b1;
          state      <= S_TALLY;
        end

        S_TALLY: begin
          if (rd_valid && rd_idx == LAST_IDX) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          // Drive the result beat
          done          <= 1'b1;
          satisfied     <= t_sat;
          conflict      <= t_conf;
          unit_valid    <= t_unit;
          unit_variable <= t_unit ? FIELD_W'(t_uvar) : '0;
          unit_polarity <= t_unit && t_upol;
          state         <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clause literal status tracker. A driver presents
// command beats on start/busy from a queue that the stimulus block fills. A
// local copy of the clause store predicts satisfied, conflict, unit and
// overflow for every accepted beat. A monitor compares each done beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import clt_pkg::*;

  localparam int SLOTS   = MAX_LITERALS_DEF;
  localparam int VB      = VAR_BITS_DEF;
  localparam logic [FIELD_W-1:0] VAR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - VB);
  localparam int RANDOM_BEATS = 1800;

  typedef struct {
    cmd_t               command;
    logic [FIELD_W-1:0] variable;
    logic               value_assigned;
    logic               polarity;
    bit                 drain;      // hold this beat until all results are back
  } command_beat_t;

  typedef struct packed {
    logic               satisfied;
    logic               conflict;
    logic               unit_valid;
    logic [FIELD_W-1:0] unit_variable;
    logic               unit_polarity;
    logic               overflow;
  } clause_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // DUT inputs start at known values
  logic               start              = 1'b0;
  cmd_t               command            = CMD_CLEAR;
  logic [FIELD_W-1:0] variable           = '0;
  logic               value_assigned     = 1'b0;
  logic               polarity_in_clause = 1'b0;

  logic               busy;
  logic               done;
  logic               satisfied;
  logic               conflict;
  logic               unit_valid;
  logic [FIELD_W-1:0] unit_variable;
  logic               unit_polarity;
  logic               overflow;

  // Predicted clause store
  logic [FIELD_W-1:0] lit_var   [SLOTS];
  logic               lit_pol   [SLOTS];
  status_t            lit_state [SLOTS];

  command_beat_t  pending_beats[$];
  clause_status_t expected_status[$];
  command_beat_t  cur_beat;
  int             beats_taken = 0;
  int             mismatches  = 0;

  clause_literal_status_tracker_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .command            (command),
    .variable           (variable),
    .value_assigned     (value_assigned),
    .polarity_in_clause (polarity_in_clause),
    .done               (done),
    .satisfied          (satisfied),
    .conflict           (conflict),
    .unit_valid         (unit_valid),
    .unit_variable      (unit_variable),
    .unit_polarity      (unit_polarity),
    .overflow           (overflow)
  );

  always #5 clk = ~clk;

  // Apply one command to the predicted store and tally the clause status
  function automatic clause_status_t apply_command(command_beat_t b);
    clause_status_t s;
    logic [FIELD_W-1:0] v;
    bit dup;
    int free_slot;
    int n_true;
    int n_open;
    s = '0;
    v = b.variable & VAR_MASK;
    dup = 1'b0;
    free_slot = -1;
    n_true = 0;
    n_open = 0;
    case (b.command)
      CMD_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) lit_state[i] = ST_EMPTY;
      end
      CMD_LOAD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (lit_state[i] != ST_EMPTY) begin
            if (lit_var[i] == v && lit_pol[i] == b.polarity) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (!dup) begin
          if (free_slot < 0) begin
            s.overflow = 1'b1;
          end else begin
            lit_var[free_slot]   = v;
            lit_pol[free_slot]   = b.polarity;
            lit_state[free_slot] = ST_UNASSIGNED;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (lit_state[i] != ST_EMPTY && lit_var[i] == v) begin
            if (b.command == CMD_ASSIGN)
              lit_state[i] = (b.value_assigned == lit_pol[i]) ? ST_TRUE : ST_FALSE;
            else
              lit_state[i] = ST_UNASSIGNED;
          end
        end
      end
    endcase
    // Tally: the last open literal is the unit candidate
    for (int i = 0; i < SLOTS; i++) begin
      if (lit_state[i] == ST_TRUE) begin
        n_true++;
      end else if (lit_state[i] == ST_UNASSIGNED) begin
        n_open++;
        s.unit_variable = lit_var[i];
        s.unit_polarity = lit_pol[i];
      end
    end
    s.satisfied  = (n_true != 0);
    s.conflict   = (n_true == 0 && n_open == 0);
    s.unit_valid = (n_true == 0 && n_open == 1);
    if (!s.unit_valid) begin
      s.unit_variable = '0;
      s.unit_polarity = 1'b0;
    end
    return s;
  endfunction

  // Draw one random bit
  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic add_beat(input cmd_t c, input logic [FIELD_W-1:0] v, input logic val,
                          input logic pol, input bit drain = 1'b0);
    command_beat_t b;
    b.command        = c;
    b.variable       = v;
    b.value_assigned = val;
    b.polarity       = pol;
    b.drain          = drain;
    pending_beats.push_back(b);
  endtask

  task automatic check_field(input string field, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: present the next beat once the current one is taken
  always @(posedge clk) begin
    logic took;
    logic gap;
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_status.push_back(apply_command(cur_beat));
        beats_taken++;
        took = 1'b1;
      end
      if (took || !start) begin
        // idle at random, except over one long stretch of back-to-back beats
        gap = (beats_taken < 700 || beats_taken >= 1100) && ($urandom_range(0, 99) < 15);
        if (pending_beats.size() != 0 && !gap &&
            !(pending_beats[0].drain && expected_status.size() != 0)) begin
          cur_beat           = pending_beats.pop_front();
          start              <= 1'b1;
          command            <= cur_beat.command;
          variable           <= cur_beat.variable;
          value_assigned     <= cur_beat.value_assigned;
          polarity_in_clause <= cur_beat.polarity;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    clause_status_t want;
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        $display("%0t: result beat with no prediction waiting", $time);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("satisfied",  FIELD_W'(want.satisfied),  FIELD_W'(satisfied));
        check_field("conflict",   FIELD_W'(want.conflict),   FIELD_W'(conflict));
        check_field("unit_valid", FIELD_W'(want.unit_valid), FIELD_W'(unit_valid));
        check_field("unit_variable", want.unit_variable, unit_variable);
        check_field("unit_polarity", FIELD_W'(want.unit_polarity), FIELD_W'(unit_polarity));
        check_field("overflow",   FIELD_W'(want.overflow),   FIELD_W'(overflow));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [FIELD_W-1:0] pool[24];
    int pool_n;
    int loads;
    int ops;
    int r;
    int target;

    // Directed: empty clause, duplicates, both polarities, reassign, full store
    add_beat(CMD_CLEAR,    20'h00000, 1'b0, 1'b0);
    add_beat(CMD_ASSIGN,   20'h00000, 1'b1, 1'b0);   // absent variable, empty clause
    add_beat(CMD_LOAD,     20'h00000, 1'b0, 1'b0);
    add_beat(CMD_LOAD,     20'h00000, 1'b1, 1'b0);   // duplicate literal
    add_beat(CMD_LOAD,     20'h00000, 1'b0, 1'b1);   // same variable, other polarity
    add_beat(CMD_ASSIGN,   20'h00000, 1'b1, 1'b0);
    add_beat(CMD_UNASSIGN, 20'h00000, 1'b0, 1'b1, 1'b1);
    add_beat(CMD_LOAD,     20'hfffff, 1'b0, 1'b1);
    add_beat(CMD_ASSIGN,   20'hfffff, 1'b0, 1'b0);
    add_beat(CMD_ASSIGN,   20'hfffff, 1'b1, 1'b1);   // reassign
    for (int i = 0; i < SLOTS - 3; i++)
      add_beat(CMD_LOAD, 20'h55555 ^ (20'h1 << i), i[0], i[1]);
    add_beat(CMD_LOAD, 20'haaaaa, 1'b1, 1'b1);       // store full
    add_beat(CMD_LOAD, 20'hfffff, 1'b0, 1'b1);       // duplicate while full

    // Random: clauses built from a small variable pool, then assign traffic
    target = pending_beats.size() + RANDOM_BEATS;
    while (pending_beats.size() < target) begin
      pool_n = ($urandom_range(0, 9) == 0) ? 24 : $urandom_range(1, 8);
      for (int i = 0; i < pool_n; i++)
        pool[i] = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 15))
                                              : FIELD_W'($urandom);
      add_beat(CMD_CLEAR, FIELD_W'($urandom), rand_bit(), rand_bit(),
               $urandom_range(0, 29) == 0);
      loads = $urandom_range(0, pool_n + 2);
      for (int i = 0; i < loads; i++)
        add_beat(CMD_LOAD, pool[$urandom_range(0, pool_n - 1)], rand_bit(), rand_bit());
      ops = $urandom_range(4, 24);
      for (int i = 0; i < ops; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10)
          add_beat(cmd_t'($urandom_range(0, 3)), FIELD_W'($urandom), rand_bit(), rand_bit());
        else if (r < 60)
          add_beat(CMD_ASSIGN, pool[$urandom_range(0, pool_n - 1)], rand_bit(), rand_bit());
        else if (r < 85)
          add_beat(CMD_UNASSIGN, pool[$urandom_range(0, pool_n - 1)], rand_bit(), rand_bit());
        else
          add_beat(CMD_LOAD, pool[$urandom_range(0, pool_n - 1)], rand_bit(), rand_bit(),
                   $urandom_range(0, 49) == 0);
      end
    end

    // Hold reset, then release it
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all results back, then let the block settle
    while (pending_beats.size() != 0 || start || expected_status.size() != 0)
      @(posedge clk);
    repeat (2 * SLOTS + 10) @(posedge clk);

    if (mismatches == 0)
      $display("[clause_literal_status_tracker_top] OK");
    else
      $display("[clause_literal_status_tracker_top] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[clause_literal_status_tracker_top] ERROR");
    $finish;
  end

endmodule
